/* design/stjs_pkg.sv */
// ----------------------------------------------------------------------------
// stjs_pkg: shared types and constants of the sorted table jump search
// Table geometry, register indexes, command and mode codes, sequencer states.
// ----------------------------------------------------------------------------
package stjs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_W     = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int STEP_W      = LEN_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int MODE_W      = 2;

  // first trial bit of the square root: largest even power of two within the length range
  localparam logic [LEN_W-1:0] SQRT_BIT0 = LEN_W'(2 ** (2 * ((LEN_W - 1) / 2)));
  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(TABLE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH = 2'd0,
    CFG_STEP   = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_ASC  = 2'd0,
    MODE_DESC = 2'd1,
    MODE_INS  = 2'd2
  } mode_e;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_LO,
    ST_INS_HI,
    ST_SQRT,
    ST_SETUP,
    ST_JUMP,
    ST_SCAN
  } state_e;

endpackage

/* design/sorted_table_jump_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_jump_search: jump search over a table of sorted signed values
// One table memory, a set of comparators and a small sequencer; entries are
// loaded by write commands and searched by search commands.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------
//  command   | in        | start_i, busy_o           | func_i, entry_index_i,
//            |           |                           | entry_value_i, search_value_i
//  result    | out       | done_o (one-cycle strobe) | found_o, position_o
//  config    | in        | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  a write command gives no result and leaves the sequencer idle.
//  a search of an empty table raises done_o without going busy; otherwise it runs, in
//  order, 2 entry reads in insertion mode, 6 square root steps when jump_step is 0,
//  a setup step, the block probes (up to length/step + 1) and the scanned entries
//  (up to step), each probe and scanned entry being a read of the single table read port.
//  busy_o is low in the cycle done_o is high, so a new command may follow at once.
//  reset clears the config registers, the sequencer and done_o; datapath registers and table contents stay undefined.
//  the receiver cannot stall: each result is taken in its strobe cycle.

module sorted_table_jump_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 func_i,
  input  logic        [stjs_pkg::ADDR_W-1:0]   entry_index_i,
  input  logic signed [stjs_pkg::VALUE_W-1:0]  entry_value_i,
  input  logic signed [stjs_pkg::VALUE_W-1:0]  search_value_i,
  output logic                                 done_o,
  output logic                                 found_o,
  output logic        [stjs_pkg::LEN_W-1:0]    position_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [stjs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [stjs_pkg::LEN_W-1:0]    cfg_data_i
);

  localparam int AW = stjs_pkg::ADDR_W;
  localparam int LW = stjs_pkg::LEN_W;
  localparam int SW = stjs_pkg::STEP_W;
  localparam int VW = stjs_pkg::VALUE_W;

  // configuration registers
  logic [LW-1:0]                length_q;
  logic [LW-1:0]                jstep_q;
  logic [stjs_pkg::MODE_W-1:0]  mode_q;

  // table memory
  logic signed [VW-1:0] mem_q [stjs_pkg::TABLE_DEPTH];
  logic signed [VW-1:0] rdata_q;
  logic [AW-1:0]        raddr;
  logic                 wr_en;

  // sequencer and datapath
  stjs_pkg::state_e state_q, state_d;
  logic signed [VW-1:0] tgt_q, tgt_d;
  logic [LW-1:0] n_q, n_d;
  logic          desc_q, desc_d, ins_q, ins_d;
  logic [LW-1:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic [LW-1:0] s_q, s_d;
  logic [SW-1:0] step_q, step_d;
  logic [AW-1:0] prev_q, prev_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [LW-1:0] end_q, end_d;
  logic          done_q, done_d, found_q, found_d;
  logic [LW-1:0] pos_q, pos_d;

  logic          accept;
  logic [LW-1:0] n_sat;
  logic [LW:0]   sq_sum;
  logic          sq_take;
  logic [LW-1:0] s_sel;
  logic [SW-1:0] step_sum;
  logic          go_on;
  logic          hit;
  logic [LW-1:0] idx_inc;

  function automatic logic [AW-1:0] last_of(input logic [SW-1:0] b, input logic [LW-1:0] n);
    logic [LW-1:0] e;
    e = (b > {1'b0, n}) ? n : b[LW-1:0];
    return AW'(e - LW'(1));
  endfunction

  assign accept      = start_i && (state_q == stjs_pkg::ST_IDLE);
  assign wr_en       = accept && (func_i == stjs_pkg::FUNC_WRITE);
  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != stjs_pkg::ST_IDLE);
  assign done_o      = done_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;

  assign n_sat    = (length_q > stjs_pkg::MAX_LEN) ? stjs_pkg::MAX_LEN : length_q;
  assign sq_sum   = {1'b0, res_q} + {1'b0, bit_q};
  assign sq_take  = ({1'b0, rem_q} >= sq_sum);
  assign s_sel    = (jstep_q != '0) ? jstep_q : res_q;
  assign step_sum = step_q + {1'b0, s_q};
  assign go_on    = desc_q ? (rdata_q > tgt_q) : (rdata_q < tgt_q);
  assign hit      = ins_q ? (rdata_q >= tgt_q) : (rdata_q == tgt_q);
  assign idx_inc  = {1'b0, idx_q} + LW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= '0;
      jstep_q  <= '0;
      mode_q   <= stjs_pkg::MODE_ASC;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        stjs_pkg::CFG_LENGTH: length_q <= cfg_data_i;
        stjs_pkg::CFG_STEP:   jstep_q  <= cfg_data_i;
        stjs_pkg::CFG_MODE:   mode_q   <= cfg_data_i[stjs_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[entry_index_i] <= entry_value_i;
    end
    rdata_q <= mem_q[raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stjs_pkg::ST_IDLE: begin
        if (accept && (func_i == stjs_pkg::FUNC_SEARCH) && (n_sat != '0)) begin
          if (mode_q == stjs_pkg::MODE_INS) begin
            state_d = stjs_pkg::ST_INS_LO;
          end else if (jstep_q == '0) begin
            state_d = stjs_pkg::ST_SQRT;
          end else begin
            state_d = stjs_pkg::ST_SETUP;
          end
        end
      end
      stjs_pkg::ST_INS_LO: begin
        state_d = (tgt_q < rdata_q) ? stjs_pkg::ST_IDLE : stjs_pkg::ST_INS_HI;
      end
      stjs_pkg::ST_INS_HI: begin
        if (tgt_q > rdata_q) begin
          state_d = stjs_pkg::ST_IDLE;
        end else if (jstep_q == '0) begin
          state_d = stjs_pkg::ST_SQRT;
        end else begin
          state_d = stjs_pkg::ST_SETUP;
        end
      end
      stjs_pkg::ST_SQRT: begin
        if (bit_q[0]) begin
          state_d = stjs_pkg::ST_SETUP;
        end
      end
      stjs_pkg::ST_SETUP: state_d = stjs_pkg::ST_JUMP;
      stjs_pkg::ST_JUMP: begin
        if (!go_on) begin
          state_d = stjs_pkg::ST_SCAN;
        end else if (step_q >= {1'b0, n_q}) begin
          state_d = stjs_pkg::ST_IDLE;
        end
      end
      stjs_pkg::ST_SCAN: begin
        if (hit || (idx_inc >= end_q)) begin
          state_d = stjs_pkg::ST_IDLE;
        end
      end
      default: state_d = stjs_pkg::ST_IDLE;
    endcase
  end

  // datapath, read address and result
  always_comb begin
    raddr   = '0;
    tgt_d   = tgt_q;
    n_d     = n_q;
    desc_d  = desc_q;
    ins_d   = ins_q;
    rem_d   = rem_q;
    res_d   = res_q;
    bit_d   = bit_q;
    s_d     = s_q;
    step_d  = step_q;
    prev_d  = prev_q;
    idx_d   = idx_q;
    end_d   = end_q;
    done_d  = 1'b0;
    found_d = found_q;
    pos_d   = pos_q;
    case (state_q)
      stjs_pkg::ST_IDLE: begin
        if (accept && (func_i == stjs_pkg::FUNC_SEARCH)) begin
          tgt_d  = search_value_i;
          n_d    = n_sat;
          desc_d = (mode_q == stjs_pkg::MODE_DESC);
          ins_d  = (mode_q == stjs_pkg::MODE_INS);
          rem_d  = n_sat;
          res_d  = '0;
          bit_d  = stjs_pkg::SQRT_BIT0;
          if (n_sat == '0) begin
            done_d  = 1'b1;
            found_d = (mode_q == stjs_pkg::MODE_INS);
            pos_d   = '0;
          end
        end
      end
      stjs_pkg::ST_INS_LO: begin
        raddr = AW'(n_q - LW'(1));
        if (tgt_q < rdata_q) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = '0;
        end
      end
      stjs_pkg::ST_INS_HI: begin
        if (tgt_q > rdata_q) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = n_q;
        end
      end
      stjs_pkg::ST_SQRT: begin
        if (sq_take) begin
          rem_d = rem_q - sq_sum[LW-1:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      stjs_pkg::ST_SETUP: begin
        s_d    = s_sel;
        step_d = {1'b0, s_sel};
        prev_d = '0;
        raddr  = last_of({1'b0, s_sel}, n_q);
      end
      stjs_pkg::ST_JUMP: begin
        if (go_on) begin
          if (step_q >= {1'b0, n_q}) begin
            done_d  = 1'b1;
            found_d = ins_q;
            pos_d   = ins_q ? n_q : '0;
          end else begin
            // probe the last entry of the next block
            prev_d = step_q[AW-1:0];
            step_d = step_sum;
            raddr  = last_of(step_sum, n_q);
          end
        end else begin
          end_d = (step_q > {1'b0, n_q}) ? n_q : step_q[LW-1:0];
          idx_d = prev_q;
          raddr = prev_q;
        end
      end
      stjs_pkg::ST_SCAN: begin
        if (hit) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = {1'b0, idx_q};
        end else if (idx_inc >= end_q) begin
          done_d  = 1'b1;
          found_d = ins_q;
          pos_d   = ins_q ? end_q : '0;
        end else begin
          idx_d = idx_inc[AW-1:0];
          raddr = idx_inc[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stjs_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q   <= tgt_d;
    n_q     <= n_d;
    desc_q  <= desc_d;
    ins_q   <= ins_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    s_q     <= s_d;
    step_q  <= step_d;
    prev_q  <= prev_d;
    idx_q   <= idx_d;
    end_q   <= end_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

endmodule
